// ----- hdl/serial_frame_retry_controller_macros.svh -----
// Assertion macros used by the retry controller checker.
`ifndef SERIAL_FRAME_RETRY_CONTROLLER_MACROS_SVH
`define SERIAL_FRAME_RETRY_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SFRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, sampled on clk, off during reset.
`define SFRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ----- hdl/sfrc_pkg.sv -----
// Shared types, codes and helpers for the serial frame retry controller.
package sfrc_pkg;

  localparam int unsigned CfgAddrW = 5;

  // Register indexes (word address bits)
  localparam logic [2:0] REG_MAX_ATTEMPTS   = 3'd0;
  localparam logic [2:0] REG_MAX_TIMEOUTS   = 3'd1;
  localparam logic [2:0] REG_MAX_RESP       = 3'd2;
  localparam logic [2:0] REG_REQ_TYPE       = 3'd3;
  localparam logic [2:0] REG_RESP_TYPE      = 3'd4;
  localparam logic [2:0] REG_MIN_LEN        = 3'd5;
  localparam logic [2:0] REG_TYPE_OFFSET    = 3'd6;

  // Reset values
  localparam logic [5:0] RST_MAX_ATTEMPTS = 6'd20;
  localparam logic [5:0] RST_MAX_TIMEOUTS = 6'd3;
  localparam logic [5:0] RST_MAX_RESP     = 6'd3;
  localparam logic [7:0] RST_REQ_TYPE     = 8'd0;
  localparam logic [7:0] RST_RESP_TYPE    = 8'd1;
  localparam logic [7:0] RST_MIN_LEN      = 8'd4;
  localparam logic [7:0] RST_TYPE_OFFSET  = 8'd1;

  // Item modes
  localparam logic [1:0] MODE_START        = 2'd0;
  localparam logic [1:0] MODE_LINK_EVENT   = 2'd1;
  localparam logic [1:0] MODE_BACKOFF_DONE = 2'd2;

  // Link status codes
  localparam logic [2:0] LS_ACK         = 3'd0;
  localparam logic [2:0] LS_FRAME       = 3'd1;
  localparam logic [2:0] LS_CANCEL      = 3'd2;
  localparam logic [2:0] LS_ACK_TIMEOUT = 3'd3;
  localparam logic [2:0] LS_RX_TIMEOUT  = 3'd4;
  localparam logic [2:0] LS_NAK         = 3'd5;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] command;
    logic       want_response;
    logic [2:0] link_status;
    logic [7:0] frame_type;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
  } in_t;

  typedef struct packed {
    logic       transmit;
    logic       start_backoff;
    logic       enqueue_request;
    logic       restart_link;
    logic       done_res;
    logic       success;
    logic [5:0] attempt;
    logic [7:0] response_length;
  } out_t;

  typedef struct packed {
    logic [5:0] max_attempts;
    logic [5:0] max_timeouts;
    logic [5:0] max_response_frames;
    logic [7:0] request_type_code;
    logic [7:0] response_type_code;
    logic [7:0] min_frame_length;
    logic [7:0] type_offset;
  } cfg_t;

  function automatic logic [5:0] sat_inc6(input logic [5:0] v);
    sat_inc6 = (v == 6'h3f) ? v : v + 6'd1;
  endfunction

endpackage

// ----- hdl/sfrc_cfg.sv -----
// APB-style register file holding the controller limits and type codes.
module sfrc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfrc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output sfrc_pkg::cfg_t                 cfg
);

  sfrc_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_attempts        <= sfrc_pkg::RST_MAX_ATTEMPTS;
      cfg_r.max_timeouts        <= sfrc_pkg::RST_MAX_TIMEOUTS;
      cfg_r.max_response_frames <= sfrc_pkg::RST_MAX_RESP;
      cfg_r.request_type_code   <= sfrc_pkg::RST_REQ_TYPE;
      cfg_r.response_type_code  <= sfrc_pkg::RST_RESP_TYPE;
      cfg_r.min_frame_length    <= sfrc_pkg::RST_MIN_LEN;
      cfg_r.type_offset         <= sfrc_pkg::RST_TYPE_OFFSET;
    end else if (wr_en) begin
      case (idx)
        sfrc_pkg::REG_MAX_ATTEMPTS: cfg_r.max_attempts        <= pwdata[5:0];
        sfrc_pkg::REG_MAX_TIMEOUTS: cfg_r.max_timeouts        <= pwdata[5:0];
        sfrc_pkg::REG_MAX_RESP:     cfg_r.max_response_frames <= pwdata[5:0];
        sfrc_pkg::REG_REQ_TYPE:     cfg_r.request_type_code   <= pwdata[7:0];
        sfrc_pkg::REG_RESP_TYPE:    cfg_r.response_type_code  <= pwdata[7:0];
        sfrc_pkg::REG_MIN_LEN:      cfg_r.min_frame_length    <= pwdata[7:0];
        sfrc_pkg::REG_TYPE_OFFSET:  cfg_r.type_offset         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sfrc_pkg::REG_MAX_ATTEMPTS: prdata = {26'd0, cfg_r.max_attempts};
      sfrc_pkg::REG_MAX_TIMEOUTS: prdata = {26'd0, cfg_r.max_timeouts};
      sfrc_pkg::REG_MAX_RESP:     prdata = {26'd0, cfg_r.max_response_frames};
      sfrc_pkg::REG_REQ_TYPE:     prdata = {24'd0, cfg_r.request_type_code};
      sfrc_pkg::REG_RESP_TYPE:    prdata = {24'd0, cfg_r.response_type_code};
      sfrc_pkg::REG_MIN_LEN:      prdata = {24'd0, cfg_r.min_frame_length};
      sfrc_pkg::REG_TYPE_OFFSET:  prdata = {24'd0, cfg_r.type_offset};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// ----- hdl/sfrc_core.sv -----
// Exchange state machine: one link decision per beat, state updated on step.
module sfrc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  sfrc_pkg::in_t       item,
  input  sfrc_pkg::cfg_t      cfg,
  output sfrc_pkg::out_t      res
);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WAIT_ACK = 2'd1,
    PH_BACKOFF  = 2'd2,
    PH_RESPONSE = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic       want_r, want_nxt;
  logic [5:0] attempt_r, attempt_nxt;
  logic [5:0] streak_r, streak_nxt;
  logic [5:0] seen_r, seen_nxt;

  logic       is_req;
  logic       finished;
  logic       backoff;
  logic       matched;

  assign is_req = (item.frame_length > cfg.type_offset) &&
                  (item.frame_type == cfg.request_type_code);

  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    want_nxt    = want_r;
    attempt_nxt = attempt_r;
    streak_nxt  = streak_r;
    seen_nxt    = seen_r;
    res         = '0;
    finished    = 1'b0;
    backoff     = 1'b1;
    matched     = 1'b0;

    case (item.mode)
      sfrc_pkg::MODE_START: begin
        if (phase_r == PH_IDLE) begin
          cmd_nxt     = item.command;
          want_nxt    = item.want_response;
          attempt_nxt = 6'd1;
          streak_nxt  = '0;
          seen_nxt    = '0;
          res.transmit = 1'b1;
          phase_nxt   = PH_WAIT_ACK;
        end
      end
      sfrc_pkg::MODE_BACKOFF_DONE: begin
        if (phase_r == PH_BACKOFF) begin
          attempt_nxt  = sfrc_pkg::sat_inc6(attempt_r);
          res.transmit = 1'b1;
          phase_nxt    = PH_WAIT_ACK;
        end
      end
      sfrc_pkg::MODE_LINK_EVENT: begin
        case (phase_r)
          PH_IDLE, PH_BACKOFF: begin
            res.enqueue_request = (item.link_status == sfrc_pkg::LS_FRAME) && is_req;
          end
          PH_WAIT_ACK: begin
            case (item.link_status)
              sfrc_pkg::LS_ACK: begin
                finished = 1'b1;
                if (want_r) begin
                  seen_nxt  = '0;
                  phase_nxt = PH_RESPONSE;
                end else begin
                  res.done_res = 1'b1;
                  res.success  = 1'b1;
                  phase_nxt    = PH_IDLE;
                end
              end
              sfrc_pkg::LS_FRAME: begin
                streak_nxt          = '0;
                res.enqueue_request = is_req;
              end
              sfrc_pkg::LS_CANCEL: streak_nxt = '0;
              sfrc_pkg::LS_ACK_TIMEOUT: begin
                streak_nxt = sfrc_pkg::sat_inc6(streak_r);
                if (streak_nxt >= cfg.max_timeouts) begin
                  res.restart_link = 1'b1;
                  res.done_res     = 1'b1;
                  finished         = 1'b1;
                  phase_nxt        = PH_IDLE;
                end
              end
              sfrc_pkg::LS_RX_TIMEOUT: backoff = 1'b0;
              sfrc_pkg::LS_NAK: begin
                res.done_res = 1'b1;
                finished     = 1'b1;
                phase_nxt    = PH_IDLE;
              end
              default: ;
            endcase
            // Non-final event: give up, back off, or resend at once
            if (!finished) begin
              if (attempt_r >= cfg.max_attempts) begin
                res.done_res = 1'b1;
                phase_nxt    = PH_IDLE;
              end else if (backoff) begin
                res.start_backoff = 1'b1;
                phase_nxt         = PH_BACKOFF;
              end else begin
                attempt_nxt  = sfrc_pkg::sat_inc6(attempt_r);
                res.transmit = 1'b1;
              end
            end
          end
          PH_RESPONSE: begin
            if ((item.link_status == sfrc_pkg::LS_FRAME) &&
                (item.frame_length >= cfg.min_frame_length)) begin
              if (item.frame_type == cfg.response_type_code) begin
                if (item.frame_command == cmd_r) begin
                  matched             = 1'b1;
                  res.done_res        = 1'b1;
                  res.success         = 1'b1;
                  res.response_length = item.frame_length;
                  phase_nxt           = PH_IDLE;
                end
              end else begin
                res.enqueue_request = is_req;
              end
            end
            // Count every unmatched event against the response budget
            if (!matched) begin
              seen_nxt = sfrc_pkg::sat_inc6(seen_r);
              if (seen_nxt >= cfg.max_response_frames) begin
                res.done_res = 1'b1;
                phase_nxt    = PH_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    res.attempt = attempt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cmd_r     <= '0;
      want_r    <= 1'b0;
      attempt_r <= '0;
      streak_r  <= '0;
      seen_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      cmd_r     <= cmd_nxt;
      want_r    <= want_nxt;
      attempt_r <= attempt_nxt;
      streak_r  <= streak_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

// ----- hdl/serial_frame_retry_controller.sv -----
// Top level: input register, decision logic, result register and config port.
//
//   channel  direction  handshake              beat
//   in       input      in_valid / in_stall    sfrc_pkg::in_t
//   out      output     out_valid / out_stall  sfrc_pkg::out_t
//   cfg      input      psel/penable/pwrite    32-bit APB-style write/read
//
// Each beat passes through the input register and then the result
// register, one beat per cycle sustained while the output is not stalled.
// The decision and the state update happen as a beat moves from the input
// register into the result register. Synchronous active-low reset clears
// valids, exchange state and config registers. A stalled result holds;
// the input register still takes a beat and then stalls the input side.
module serial_frame_retry_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sfrc_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sfrc_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfrc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  sfrc_pkg::cfg_t cfg;
  sfrc_pkg::in_t  s1_data_r;
  logic           s1_valid_r, s1_valid_nxt;
  sfrc_pkg::out_t out_data_r;
  sfrc_pkg::out_t res;
  logic           out_valid_r, out_valid_nxt;
  logic           s1_adv;
  logic           in_fire;

  sfrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfrc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .item  (s1_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Advance the input register whenever the result register is free
  assign s1_adv        = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && !s1_adv;
  assign in_fire       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

endmodule

// ----- hdl/sfrc_chk.sv -----
// Port-level checker for the retry controller, bound to the top level.
`include "serial_frame_retry_controller_macros.svh"

module sfrc_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input sfrc_pkg::out_t out_data
);

  // A stalled result beat holds until taken
  `SFRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Success only ever comes with a finished exchange
  `SFRC_ASSERT_NOW(a_success_done, out_valid && out_data.success, out_data.done_res)

  // A link restart always ends the exchange as a failure
  `SFRC_ASSERT_NOW(a_restart_fail, out_valid && out_data.restart_link,
                   out_data.done_res && !out_data.success && !out_data.transmit)

  // A response length is reported only on a successful finish
  `SFRC_ASSERT_NOW(a_rlen_success, out_valid && (out_data.response_length != 8'd0),
                   out_data.success && !out_data.enqueue_request)

  // Never send together with a backoff or a finish on the same beat
  `SFRC_ASSERT_NOW(a_tx_xor_bo, out_valid && out_data.transmit,
                   !out_data.start_backoff && !out_data.done_res)

endmodule

bind serial_frame_retry_controller sfrc_chk u_sfrc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
